@@ rtl/strm_pkg.sv @@
// Shared constants, types and helper functions for the sparse table range-minimum block.
// Depends on nothing; every other file imports it.
package strm_pkg;

  // Array capacity and element width.
  localparam int MAX_LEN     = 1024;
  localparam int VALUE_WIDTH = 32;

  // Derived sizes.
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int LEVELS    = $clog2(MAX_LEN) + 1;
  localparam int LVL_W     = $clog2(LEVELS + 1);
  localparam int TBL_DEPTH = MAX_LEN * LEVELS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

  // Status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_TABLE = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  // Operation class decided at the front.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOAD_LAST,
    OP_QUERY
  } op_t;

  // One queued command.
  typedef struct packed {
    op_t                     op;
    logic [VALUE_WIDTH-1:0]  value;
    logic [IDX_W-1:0]        left;
    logic [IDX_W-1:0]        right;
  } cmd_t;

  // Execution states of the back end.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_LEVEL,
    ST_RD_A,
    ST_RD_B,
    ST_VAL_A,
    ST_VAL_B
  } state_t;

  // Floor of log2 for a nonzero range length.
  function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] n);
    logic [LVL_W-1:0] k;
    k = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (n[b]) k = LVL_W'(b);
    end
    return k;
  endfunction

endpackage

@@ rtl/sparse_table_range_min_core.sv @@
// Top level of the sparse table range-minimum block.
// Depends on strm_pkg, strm_front and strm_back.
//
// Usage: a command transfers at a rising edge where start is high and busy is low.
// kind = 0 loads value as the next array element; last_element on a load ends
// the array and builds the table. kind = 1 queries the minimum over [left, right].
// Each query produces one result on min_index, min_value and status, shown for
// exactly one cycle while done is high; loads produce no result.
// The receiver cannot stall, so results are never held back.
// A load is stored as the back end pops it. A query with a valid range passes
// ST_RD_A, ST_RD_B, ST_VAL_A and ST_VAL_B, reading two table entries and two
// elements through the single read port of each memory; an early-rejected query
// answers from ST_IDLE. The build after a last load writes N level-zero entries,
// then computes each higher table entry through the same states, visiting
// ST_LEVEL once per level, paced by the sequential read ports of both memories.
// A two-entry queue sits between the front and back; busy rises while it is full.
// Reset clears the queue, the element count and the table-ready flag; memory
// contents are not cleared and need no clearing pass.
module sparse_table_range_min_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind,
  input  logic [strm_pkg::VALUE_WIDTH-1:0] value,
  input  logic                             last_element,
  input  logic [strm_pkg::IDX_W-1:0]       left,
  input  logic [strm_pkg::IDX_W-1:0]       right,
  output logic                             done,
  output logic [strm_pkg::IDX_W-1:0]       min_index,
  output logic [strm_pkg::VALUE_WIDTH-1:0] min_value,
  output logic [1:0]                       status
);
  import strm_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Command intake and queue.
  strm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .value        (value),
    .last_element (last_element),
    .left         (left),
    .right        (right),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Execution of loads, builds and queries.
  strm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .done      (done),
    .min_index (min_index),
    .min_value (min_value),
    .status    (status)
  );

endmodule

@@ rtl/strm_front.sv @@
// Front end: accepts commands, classifies them and holds them in a short queue.
// Depends on strm_pkg.
module strm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic [strm_pkg::VALUE_WIDTH-1:0] value,
  input  logic                            last_element,
  input  logic [strm_pkg::IDX_W-1:0]      left,
  input  logic [strm_pkg::IDX_W-1:0]      right,
  output logic                            cmd_valid,
  output strm_pkg::cmd_t                  cmd,
  input  logic                            cmd_pop
);
  import strm_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  cmd_t              incoming;
  logic              push;
  logic              pop;

  // Classify the incoming item.
  always_comb begin
    incoming.value = value;
    incoming.left  = left;
    incoming.right = right;
    if (kind) incoming.op = OP_QUERY;
    else if (last_element) incoming.op = OP_LOAD_LAST;
    else incoming.op = OP_LOAD;
  end

  assign busy      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = entries[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= incoming;
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

@@ rtl/strm_back.sv @@
// Back end: element store, minimum-position table, table build sequencer and query unit.
// Depends on strm_pkg.
module strm_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  strm_pkg::cmd_t                   cmd,
  output logic                             cmd_pop,
  output logic                             done,
  output logic [strm_pkg::IDX_W-1:0]       min_index,
  output logic [strm_pkg::VALUE_WIDTH-1:0] min_value,
  output logic [1:0]                       status
);
  import strm_pkg::*;

  logic [VALUE_WIDTH-1:0] elem_mem [MAX_LEN];
  logic [IDX_W-1:0]       tbl_mem  [TBL_DEPTH];

  state_t state, state_next;

  logic [CNT_W-1:0]       count;
  logic                   table_ready;
  logic                   is_query;
  logic [LVL_W-1:0]       level;
  logic [CNT_W-1:0]       idx;
  logic [IDX_W-1:0]       row_a;
  logic [IDX_W-1:0]       row_b;
  logic [LVL_W-1:0]       col;
  logic [IDX_W-1:0]       pos_a;
  logic [VALUE_WIDTH-1:0] val_a;
  logic [IDX_W-1:0]       tbl_rd;
  logic [VALUE_WIDTH-1:0] elem_rd;

  logic [TBL_AW-1:0]      tbl_raddr;
  logic [TBL_AW-1:0]      tbl_waddr;
  logic                   tbl_we;
  logic [IDX_W-1:0]       tbl_wdata;
  logic [IDX_W-1:0]       elem_raddr;

  logic [CNT_W-1:0]       load_base;
  logic [CNT_W-1:0]       load_count;
  logic                   load_fits;
  logic [CNT_W:0]         half;
  logic [CNT_W:0]         span;
  logic                   level_go;
  logic [CNT_W:0]         idx_inc;
  logic                   row_more;
  logic                   left_wins;
  logic                   range_bad;
  logic [CNT_W-1:0]       qlen;
  logic [LVL_W-1:0]       qk;
  logic [CNT_W-1:0]       qrow_b;

  // Shared arithmetic for loads, level control and queries.
  always_comb begin
    load_base  = table_ready ? '0 : count;
    load_fits  = (load_base < CNT_W'(MAX_LEN));
    load_count = load_fits ? load_base + 1'b1 : load_base;
    span       = (CNT_W + 1)'(1) << level;
    half       = (CNT_W + 1)'(1) << (level - 1'b1);
    level_go   = (level < LVL_W'(LEVELS)) && (span <= {1'b0, count});
    idx_inc    = {1'b0, idx} + 1'b1;
    row_more   = (idx_inc + (half << 1)) <= {1'b0, count};
    left_wins  = $signed(val_a) < $signed(elem_rd);
    range_bad  = (cmd.left > cmd.right) || ({1'b0, cmd.right} >= count);
    qlen       = CNT_W'(cmd.right) - CNT_W'(cmd.left) + 1'b1;
    qk         = floor_log2(qlen);
    qrow_b     = CNT_W'(cmd.right) - (CNT_W'(1) << qk) + 1'b1;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_LOAD_LAST && load_count != '0) state_next = ST_INIT;
          else if (cmd.op == OP_QUERY && table_ready && !range_bad) state_next = ST_RD_A;
        end
      end
      ST_INIT:  if (idx_inc == {1'b0, count}) state_next = ST_LEVEL;
      ST_LEVEL: state_next = level_go ? ST_RD_A : ST_IDLE;
      ST_RD_A:  state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_VAL_A;
      ST_VAL_A: state_next = ST_VAL_B;
      ST_VAL_B: begin
        if (is_query) state_next = ST_IDLE;
        else state_next = row_more ? ST_RD_A : ST_LEVEL;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory controls and queue pop. The right block's position is read again
  // in the value phase so that it is still on the read port at the compare.
  always_comb begin
    cmd_pop    = (state == ST_IDLE) && cmd_valid;
    tbl_raddr  = TBL_AW'(row_a) * TBL_AW'(LEVELS) + TBL_AW'(col);
    if (state == ST_RD_B || state == ST_VAL_A)
      tbl_raddr = TBL_AW'(row_b) * TBL_AW'(LEVELS) + TBL_AW'(col);
    elem_raddr = tbl_rd;
    tbl_waddr  = TBL_AW'(idx) * TBL_AW'(LEVELS) + TBL_AW'(level);
    tbl_we     = (state == ST_INIT) || (state == ST_VAL_B && !is_query);
    tbl_wdata  = IDX_W'(idx);
    if (state == ST_VAL_B) tbl_wdata = left_wins ? pos_a : tbl_rd;
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rd <= tbl_mem[tbl_raddr];
    if (cmd_pop && cmd.op != OP_QUERY && load_fits)
      elem_mem[load_base[IDX_W-1:0]] <= cmd.value;
    elem_rd <= elem_mem[elem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      table_ready <= 1'b0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_QUERY) begin
              if (!table_ready || range_bad) done <= 1'b1;
            end else begin
              count       <= load_count;
              table_ready <= 1'b0;
            end
          end
        end
        ST_LEVEL: if (!level_go) table_ready <= (count != '0);
        ST_VAL_B: if (is_query) done <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx      <= '0;
        level    <= '0;
        is_query <= (cmd.op == OP_QUERY);
        row_a    <= cmd.left;
        row_b    <= qrow_b[IDX_W-1:0];
        col      <= qk;
        min_index <= '0;
        min_value <= '0;
        status    <= table_ready ? STATUS_RANGE : STATUS_NO_TABLE;
      end
      ST_INIT: begin
        idx <= idx_inc[CNT_W-1:0];
        if (idx_inc == {1'b0, count}) level <= LVL_W'(1);
      end
      ST_LEVEL: begin
        idx   <= '0;
        row_a <= '0;
        row_b <= half[IDX_W-1:0];
        col   <= level - 1'b1;
      end
      ST_RD_B:  pos_a <= tbl_rd;
      ST_VAL_A: val_a <= elem_rd;
      ST_VAL_B: begin
        if (is_query) begin
          min_index <= left_wins ? pos_a : tbl_rd;
          min_value <= left_wins ? val_a : elem_rd;
          status    <= STATUS_OK;
        end else if (row_more) begin
          idx   <= idx_inc[CNT_W-1:0];
          row_a <= idx_inc[IDX_W-1:0];
          row_b <= IDX_W'(idx_inc + half);
        end else begin
          level <= level + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
